>>> sv/msncg_pkg.sv
// Shared types and constants for the MIDI single-note chord generator.
`timescale 1ns / 1ps
package msncg_pkg;

    localparam int MAX_CHORD_NOTES_DEF = 6;
    localparam int PITCH_COUNT = 128;
    localparam int INTERVAL_REGS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_CHORD_SIZE = 3'd0;

    localparam logic [3:0] TYPE_NOTE_ON = 4'h9;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic [6:0] PITCH_MAX = 7'd127;

    typedef struct packed {
        logic        is_midi;
        logic [7:0]  status_byte;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [31:0] frame_time;
    } in_item_t;

    typedef struct packed {
        logic        out_is_midi;
        logic [7:0]  out_status;
        logic [6:0]  out_pitch;
        logic [6:0]  out_velocity;
        logic [31:0] out_time;
        logic        last_of_run;
    } out_item_t;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        logic        is_midi;
        logic        is_on;
        logic        is_off;
        logic [7:0]  status_byte;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [31:0] frame_time;
    } work_t;

endpackage

>>> sv/msncg_front.sv
// Front part: accepts input beats, classifies them and queues them for the back part.
`timescale 1ns / 1ps
module msncg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  msncg_pkg::in_item_t in_item,
    output logic                work_valid,
    input  logic                work_take,
    output msncg_pkg::work_t    work
);
    import msncg_pkg::*;

    localparam int DEPTH = 2;

    work_t     q_reg [DEPTH];
    logic      wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    work_t     w;

    always_comb
    begin
        w.is_midi = in_item.is_midi;
        w.is_on = in_item.is_midi && in_item.status_byte[7:4] == TYPE_NOTE_ON
            && in_item.data_two != 7'd0;
        w.is_off = in_item.is_midi && !w.is_on
            && (in_item.status_byte[7:4] == TYPE_NOTE_ON
                || in_item.status_byte[7:4] == TYPE_NOTE_OFF);
        w.status_byte = in_item.is_midi ? in_item.status_byte : 8'd0;
        w.pitch = in_item.is_midi ? in_item.data_one : 7'd0;
        w.velocity = in_item.is_midi ? in_item.data_two : 7'd0;
        w.frame_time = in_item.frame_time;
    end

    assign full = (cnt_reg == 2'(DEPTH));
    assign work_valid = (cnt_reg != 2'd0);
    assign work = q_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push && !full)
        begin
            wr_next = ~wr_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (work_take && work_valid)
        begin
            rd_next = ~rd_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            q_reg[wr_reg] <= w;
        end
    end
endmodule

>>> sv/msncg_back.sv
// Back part: note state, chord building and release, and the result register.
`timescale 1ns / 1ps
module msncg_back #(
    parameter int MAX_CHORD_NOTES = msncg_pkg::MAX_CHORD_NOTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 work_valid,
    output logic                                 work_take,
    input  msncg_pkg::work_t                     work,
    input  logic                                 cfg_we,
    input  logic [msncg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msncg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                 empty,
    input  logic                                 pop,
    output msncg_pkg::out_item_t                 out_item
);
    import msncg_pkg::*;

    localparam int LEN_MAX = (MAX_CHORD_NOTES < INTERVAL_REGS) ? MAX_CHORD_NOTES
                                                              : INTERVAL_REGS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RDHELD  = 4'd1;
    localparam logic [3:0] S_UPDATE  = 4'd2;
    localparam logic [3:0] S_FWD     = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_ROOTRD  = 4'd5;
    localparam logic [3:0] S_BCHK    = 4'd6;
    localparam logic [3:0] S_BRD     = 4'd7;
    localparam logic [3:0] S_BEMIT   = 4'd8;
    localparam logic [3:0] S_REL     = 4'd9;
    localparam logic [3:0] S_FLUSH   = 4'd10;

    // Held count, velocity and channel share one memory word per pitch.
    logic [18:0] held_mem [PITCH_COUNT];
    logic [18:0] held_rd_reg;
    logic [6:0]  rd_addr;
    logic [PITCH_COUNT-1:0] valid_reg;   // entry written since reset
    logic [PITCH_COUNT-1:0] gen_reg;     // generated marks
    logic [3:0]  gen_ch_reg [PITCH_COUNT];
    logic [3:0]  gen_ch_rd_reg;
    logic [6:0]  rel_addr;
    logic [PITCH_COUNT-1:0] nz_reg;      // held count nonzero

    logic [2:0]  size_reg;
    logic [6:0]  iv_reg [INTERVAL_REGS];
    logic [7:0]  distinct_reg;

    logic [3:0]  state_reg, state_next;
    work_t       cur_reg;
    logic [7:0]  before_reg;
    logic [7:0]  cnt_rd;
    logic [7:0]  idx_reg;       // scan pitch, wide enough to hold the count
    logic [2:0]  iv_idx_reg;
    logic [6:0]  root_reg, rvel_reg;
    logic [3:0]  rch_reg;
    logic [6:0]  cand_reg;
    logic        pend_reg;      // a result is buffered awaiting a successor
    out_item_t   pend_item_reg;
    out_item_t   res_reg;
    logic        res_full_reg;

    logic [2:0]  len;
    logic        slot_free;
    logic        emit;
    out_item_t   emit_item;
    logic        fin;           // mark buffered result as last

    // The scan reads the memory at the scan pitch so the root entry is ready in S_ROOTRD.
    assign rd_addr = (state_reg == S_SCAN) ? idx_reg[6:0] : cand_reg;
    assign cnt_rd = held_rd_reg[18:11];
    assign len = (size_reg > 3'(LEN_MAX)) ? 3'(LEN_MAX) : size_reg;
    assign empty = !res_full_reg;
    assign out_item = res_reg;
    assign slot_free = !res_full_reg || pop;
    assign work_take = (state_reg == S_IDLE) && work_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 3'd1;
            for (int i = 0; i < INTERVAL_REGS; i++)
            begin
                iv_reg[i] <= 7'd0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CHORD_SIZE)
            begin
                size_reg <= cfg_data[2:0];
            end
            else if (int'(cfg_index) <= INTERVAL_REGS)
            begin
                iv_reg[cfg_index - 3'd1] <= cfg_data;
            end
        end
    end

    logic [7:0] cand_sum;
    logic [7:0] top_sum;
    logic [6:0] cur_iv;
    assign cur_iv = iv_reg[iv_idx_reg];
    assign cand_sum = {1'b0, root_reg} + {1'b0, cur_iv};
    assign top_sum = {1'b0, root_reg} + {1'b0, iv_reg[len - 3'd1]};

    logic [7:0] cnt_new;
    logic       hit_on, hit_off;
    always_comb
    begin
        hit_on = cur_reg.is_on;
        hit_off = cur_reg.is_off && cnt_rd != 8'd0;
        cnt_new = cnt_rd;
        if (hit_on && cnt_rd != COUNT_MAX)
        begin
            cnt_new = cnt_rd + 8'd1;
        end
        else if (hit_off)
        begin
            cnt_new = cnt_rd - 8'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        emit = 1'b0;
        fin = 1'b0;
        emit_item = '0;
        emit_item.out_is_midi = 1'b1;
        emit_item.out_time = cur_reg.frame_time;
        case (state_reg)
            S_IDLE:
            begin
                if (work_valid)
                begin
                    state_next = S_RDHELD;
                end
            end
            S_RDHELD:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_FWD;
            end
            S_FWD:
            begin
                emit = 1'b1;
                emit_item.out_is_midi = cur_reg.is_midi;
                emit_item.out_status = cur_reg.status_byte;
                emit_item.out_pitch = cur_reg.pitch;
                emit_item.out_velocity = cur_reg.velocity;
                if (cur_reg.is_on && before_reg == 8'd0 && distinct_reg == 8'd1)
                begin
                    state_next = S_BCHK;
                end
                else if (before_reg == 8'd1
                         && (distinct_reg == 8'd2 || distinct_reg == 8'd0))
                begin
                    state_next = S_REL;
                end
                else if (cur_reg.is_off && before_reg >= 8'd2 && distinct_reg == 8'd1)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_SCAN:
            begin
                if (nz_reg[idx_reg[6:0]])
                begin
                    state_next = S_ROOTRD;
                end
            end
            S_ROOTRD:
            begin
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (len == 3'd0 || top_sum > 8'(PITCH_MAX)
                    || {1'b0, iv_idx_reg} >= {1'b0, len})
                begin
                    state_next = S_FLUSH;
                end
                else if (cur_iv != 7'd0 && !cand_sum[7])
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                state_next = S_BEMIT;
            end
            S_BEMIT:
            begin
                if (cnt_rd == 8'd0 && !gen_reg[cand_reg])
                begin
                    if (slot_free || !pend_reg)
                    begin
                        emit = 1'b1;
                        emit_item.out_status = {TYPE_NOTE_ON, rch_reg};
                        emit_item.out_pitch = cand_reg;
                        emit_item.out_velocity = rvel_reg;
                        state_next = S_BCHK;
                    end
                end
                else
                begin
                    state_next = S_BCHK;
                end
            end
            S_REL:
            begin
                if (idx_reg[7])
                begin
                    state_next = S_FLUSH;
                end
                else if (gen_reg[idx_reg[6:0]])
                begin
                    if (slot_free || !pend_reg)
                    begin
                        emit = 1'b1;
                        emit_item.out_status = {TYPE_NOTE_OFF, gen_ch_rd_reg};
                        emit_item.out_pitch = idx_reg[6:0];
                    end
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    fin = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // An emit must wait while a buffered result cannot move on.
        if (emit && pend_reg && !slot_free)
        begin
            emit = 1'b0;
            state_next = state_reg;
        end
    end

    // The release sweep fetches the channel of the pitch it will look at next cycle.
    assign rel_addr = (state_reg == S_REL && !idx_reg[7]
                       && (!gen_reg[idx_reg[6:0]] || emit)) ? idx_reg[6:0] + 7'd1
                                                            : idx_reg[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            gen_reg <= '0;
            nz_reg <= '0;
            distinct_reg <= 8'd0;
            pend_reg <= 1'b0;
            res_full_reg <= 1'b0;
            idx_reg <= 8'd0;
            iv_idx_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && res_full_reg)
            begin
                res_full_reg <= 1'b0;
            end
            if (emit)
            begin
                if (pend_reg)
                begin
                    res_full_reg <= 1'b1;
                end
                pend_reg <= 1'b1;
            end
            if (fin)
            begin
                res_full_reg <= 1'b1;
                pend_reg <= 1'b0;
            end
            case (state_reg)
                S_UPDATE:
                begin
                    if (hit_on || hit_off)
                    begin
                        valid_reg[cand_reg] <= 1'b1;
                        nz_reg[cand_reg] <= (cnt_new != 8'd0);
                    end
                    if (hit_on && cnt_rd == 8'd0)
                    begin
                        distinct_reg <= distinct_reg + 8'd1;
                    end
                    if (hit_off && cnt_rd == 8'd1)
                    begin
                        distinct_reg <= distinct_reg - 8'd1;
                    end
                    idx_reg <= 8'd0;
                    iv_idx_reg <= 3'd0;
                end
                S_SCAN:
                begin
                    if (!nz_reg[idx_reg[6:0]])
                    begin
                        idx_reg <= idx_reg + 8'd1;
                    end
                end
                S_BEMIT:
                begin
                    if (state_next == S_BCHK)
                    begin
                        iv_idx_reg <= iv_idx_reg + 3'd1;
                        if (emit)
                        begin
                            gen_reg[cand_reg] <= 1'b1;
                        end
                    end
                end
                S_BCHK:
                begin
                    if (state_next == S_BCHK)
                    begin
                        iv_idx_reg <= iv_idx_reg + 3'd1;
                    end
                end
                S_REL:
                begin
                    if (!idx_reg[7] && (!gen_reg[idx_reg[6:0]] || emit))
                    begin
                        idx_reg <= idx_reg + 8'd1;
                        gen_reg[idx_reg[6:0]] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        held_rd_reg <= valid_reg[rd_addr] ? held_mem[rd_addr] : 19'd0;
        gen_ch_rd_reg <= gen_ch_reg[rel_addr];
        if (work_take)
        begin
            cur_reg <= work;
            cand_reg <= work.pitch;
            before_reg <= distinct_reg;
        end
        if (state_reg == S_UPDATE)
        begin
            if (hit_on)
            begin
                held_mem[cand_reg] <= {cnt_new, cur_reg.velocity, cur_reg.status_byte[3:0]};
            end
            else if (hit_off)
            begin
                held_mem[cand_reg] <= (cnt_new == 8'd0) ? 19'd0
                                    : {cnt_new, held_rd_reg[10:0]};
            end
            root_reg <= cur_reg.pitch;
            rvel_reg <= cur_reg.velocity;
            rch_reg <= cur_reg.status_byte[3:0];
        end
        if (state_reg == S_SCAN && nz_reg[idx_reg[6:0]])
        begin
            cand_reg <= idx_reg[6:0];
            root_reg <= idx_reg[6:0];
        end
        if (state_reg == S_ROOTRD)
        begin
            rvel_reg <= held_rd_reg[10:4];
            rch_reg <= held_rd_reg[3:0];
        end
        if (state_reg == S_BCHK)
        begin
            cand_reg <= cand_sum[6:0];
        end
        if (state_reg == S_BEMIT && emit)
        begin
            gen_ch_reg[cand_reg] <= rch_reg;
        end
        if (emit)
        begin
            pend_item_reg <= emit_item;
            if (pend_reg)
            begin
                res_reg <= pend_item_reg;
            end
        end
        if (fin)
        begin
            res_reg <= pend_item_reg;
            res_reg.last_of_run <= 1'b1;
        end
    end
endmodule

>>> sv/midi_single_note_chord_generator.sv
// Top level of the MIDI single-note chord generator.
// Channel   Handshake        Payload
// input     push / full      in_item  (in_item_t)
// result    empty / pop      out_item (out_item_t)
// config    cfg_we           cfg_index, cfg_data
// A plain event passes the read, update, forward and flush states; each chord interval
// passes the check state, and also the read and emit states when its interval is nonzero
// and its note is in range. A release sweeps all 128 generated marks, and a many-to-one
// drop scans up to 128 pitches for the lowest held one.
// Reset clears counts through per-pitch valid bits at once; no clearing pass.
// A two-entry queue parts intake from processing; the back part stalls on a full
// result register.
`timescale 1ns / 1ps
module midi_single_note_chord_generator #(
    parameter int MAX_CHORD_NOTES = msncg_pkg::MAX_CHORD_NOTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  msncg_pkg::in_item_t              in_item,
    output logic                             empty,
    input  logic                             pop,
    output msncg_pkg::out_item_t             out_item,
    input  logic                             cfg_we,
    input  logic [msncg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msncg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import msncg_pkg::*;

    logic  work_valid, work_take;
    work_t work;

    msncg_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .work_valid(work_valid), .work_take(work_take), .work(work)
    );

    msncg_back #(.MAX_CHORD_NOTES(MAX_CHORD_NOTES)) u_back (
        .clk(clk), .rst_n(rst_n), .work_valid(work_valid), .work_take(work_take),
        .work(work), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .empty(empty), .pop(pop), .out_item(out_item)
    );
endmodule

>>> sim/midi_single_note_chord_generator_tb.sv
// Self-checking testbench for the MIDI single-note chord generator.
`timescale 1ns / 1ps
module midi_single_note_chord_generator_tb;
    import msncg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_A = 3'd1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_PER_PHASE = 45;
    localparam int PHASES = 5;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    in_item_t in_item = '0;
    out_item_t out_item;
    logic full;
    logic empty;

    midi_single_note_chord_generator uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Predictor state.
    logic [7:0] key_count [PITCH_COUNT];
    logic [6:0] key_vel [PITCH_COUNT];
    logic [3:0] note_chan [PITCH_COUNT];
    bit chord_mark [PITCH_COUNT];
    logic [3:0] chord_chan [PITCH_COUNT];
    int held_pitches;
    logic [2:0] size_reg;
    logic [6:0] interval_reg [INTERVAL_REGS];

    out_item_t event_beats[$];
    out_item_t pending_beats[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_request = 0;
    int mismatches = 0;
    int items_sent = 0;
    int beats_seen = 0;
    int chord_notes_seen = 0;
    int quiet_cycles = 0;

    function automatic out_item_t make_beat(logic m, logic [7:0] s, logic [6:0] p,
                                            logic [6:0] v, logic [31:0] t, logic last);
        out_item_t b;
        b.out_is_midi = m;
        b.out_status = s;
        b.out_pitch = p;
        b.out_velocity = v;
        b.out_time = t;
        b.last_of_run = last;
        return b;
    endfunction

    function automatic in_item_t make_event(logic m, logic [7:0] s, logic [6:0] d1,
                                            logic [6:0] d2, logic [31:0] t);
        in_item_t e;
        e.is_midi = m;
        e.status_byte = s;
        e.data_one = d1;
        e.data_two = d2;
        e.frame_time = t;
        return e;
    endfunction

    function automatic void add_chord(int root, logic [6:0] vel, logic [3:0] ch,
                                      logic [31:0] t);
        int len;
        int p;
        int iv;
        len = (size_reg > 6) ? 6 : size_reg;
        if (len == 0) return;
        if (root > 127 - int'(interval_reg[len-1])) return;
        for (int i = 0; i < len; i++) begin
            iv = interval_reg[i];
            p = root + iv;
            if (iv == 0 || p > 127) continue;
            if (key_count[p] == 0 && !chord_mark[p] && event_beats.size() < 7) begin
                event_beats.push_back(make_beat(1'b1, {TYPE_NOTE_ON, ch}, p[6:0], vel, t, 1'b0));
                chord_mark[p] = 1'b1;
                chord_chan[p] = ch;
            end
        end
    endfunction

    function automatic void drop_chord(logic [31:0] t);
        for (int p = 0; p < PITCH_COUNT; p++) begin
            if (chord_mark[p] && event_beats.size() < 7) begin
                event_beats.push_back(make_beat(1'b1, {TYPE_NOTE_OFF, chord_chan[p]},
                                                p[6:0], 7'd0, t, 1'b0));
                chord_mark[p] = 1'b0;
            end
        end
    endfunction

    // Works out every beat that one accepted event causes, in order.
    function automatic void predict_chord_event(in_item_t e);
        int prior;
        int p;
        logic [3:0] kind;
        prior = held_pitches;
        kind = e.status_byte[7:4];
        p = e.data_one;
        event_beats.delete();
        if (!e.is_midi) begin
            event_beats.push_back(make_beat(1'b0, 8'd0, 7'd0, 7'd0, e.frame_time, 1'b0));
        end else if (kind == TYPE_NOTE_ON && e.data_two != 0) begin
            if (key_count[p] == 0) held_pitches++;
            if (key_count[p] != COUNT_MAX) key_count[p]++;
            key_vel[p] = e.data_two;
            note_chan[p] = e.status_byte[3:0];
            event_beats.push_back(make_beat(1'b1, e.status_byte, e.data_one, e.data_two,
                                            e.frame_time, 1'b0));
            if (prior == 0 && held_pitches == 1)
                add_chord(p, e.data_two, e.status_byte[3:0], e.frame_time);
            else if (prior == 1 && held_pitches == 2)
                drop_chord(e.frame_time);
        end else if (kind == TYPE_NOTE_OFF || kind == TYPE_NOTE_ON) begin
            if (key_count[p] != 0) begin
                key_count[p]--;
                if (key_count[p] == 0) begin
                    held_pitches--;
                    key_vel[p] = 7'd0;
                    note_chan[p] = 4'd0;
                end
            end
            event_beats.push_back(make_beat(1'b1, e.status_byte, e.data_one, e.data_two,
                                            e.frame_time, 1'b0));
            if (prior == 1 && held_pitches == 0) begin
                drop_chord(e.frame_time);
            end else if (prior >= 2 && held_pitches == 1) begin
                for (int q = 0; q < PITCH_COUNT; q++) begin
                    if (key_count[q] != 0) begin
                        add_chord(q, key_vel[q], note_chan[q], e.frame_time);
                        break;
                    end
                end
            end
        end else begin
            event_beats.push_back(make_beat(1'b1, e.status_byte, e.data_one, e.data_two,
                                            e.frame_time, 1'b0));
        end
        event_beats[event_beats.size()-1].last_of_run = 1'b1;
    endfunction

    task automatic send_event(in_item_t e, bit typed, out_item_t want);
        while (tx_idle_on && $urandom_range(0, 99) < 32) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= e;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_chord_event(e);
        // Rows with a typed-in answer still run through the predictor to keep its state.
        if (typed && event_beats.size() == 1) event_beats[0] = want;
        foreach (event_beats[i]) pending_beats.push_back(event_beats[i]);
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0) @(posedge clk);
    endtask

    task automatic load_chord(logic [2:0] sz, logic [6:0] iv [INTERVAL_REGS]);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_CHORD_SIZE;
        cfg_data <= {4'd0, sz};
        @(posedge clk);
        size_reg = sz;
        for (int i = 0; i < INTERVAL_REGS; i++) begin
            cfg_index <= REG_INTERVAL_A + i[2:0];
            cfg_data <= iv[i];
            @(posedge clk);
            interval_reg[i] = iv[i];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed note traffic on a narrow keyboard, with some noise.
    function automatic in_item_t random_event();
        int r;
        int p;
        int start;
        logic [3:0] ch;
        logic [6:0] vel;
        r = $urandom_range(0, 99);
        ch = 4'($urandom_range(0, 15));
        if (r < 5)
            return make_event(1'b0, 8'($urandom), 7'($urandom), 7'($urandom), $urandom);
        if (r < 12)
            return make_event(1'b1, 8'($urandom), 7'($urandom), 7'($urandom), $urandom);
        if (r < 55 && held_pitches < 3) begin
            p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(40, 72);
            vel = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
            return make_event(1'b1, {TYPE_NOTE_ON, ch}, p[6:0], vel, $urandom);
        end
        p = $urandom_range(0, 127);
        if (held_pitches != 0 && $urandom_range(0, 9) != 0) begin
            start = $urandom_range(0, 127);
            for (int k = 0; k < PITCH_COUNT; k++) begin
                if (key_count[(start + k) % PITCH_COUNT] != 0) begin
                    p = (start + k) % PITCH_COUNT;
                    break;
                end
            end
        end
        return make_event(1'b1, {TYPE_NOTE_OFF, ch}, p[6:0], 7'($urandom), $urandom);
    endfunction

    // Result side: checks each beat and drives pop, with idling and hold-offs.
    initial begin : result_side
        int hold_left;
        out_item_t want;
        bit bad;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                beats_seen++;
                if (out_item.out_is_midi && out_item.out_status[7:4] != 4'hF
                    && out_item.last_of_run == 1'b0)
                    chord_notes_seen++;
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected beat %p", out_item);
                end else begin
                    want = pending_beats.pop_front();
                    bad = out_item.out_is_midi !== want.out_is_midi
                        || out_item.out_status !== want.out_status
                        || out_item.out_pitch !== want.out_pitch
                        || out_item.out_velocity !== want.out_velocity
                        || out_item.out_time !== want.out_time
                        || out_item.last_of_run !== want.last_of_run;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: beat mismatch, expected %p, got %p", want, out_item);
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !(rx_idle_on && $urandom_range(0, 99) < 32);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL midi_single_note_chord_generator");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t rows[$];
        logic [6:0] ivs [INTERVAL_REGS];
        out_item_t none;
        none = '0;
        for (int p = 0; p < PITCH_COUNT; p++) begin
            key_count[p] = '0;
            key_vel[p] = '0;
            note_chan[p] = '0;
            chord_mark[p] = 1'b0;
            chord_chan[p] = '0;
        end
        held_pitches = 0;
        size_reg = 3'd1;
        foreach (interval_reg[i]) interval_reg[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Major chord with an octave on top.
        ivs = '{7'd4, 7'd7, 7'd12, 7'd0, 7'd0, 7'd0};
        load_chord(3'd3, ivs);

        rows.push_back('{make_event(1'b0, 8'h00, 7'd0, 7'd0, 32'hFFFF_FFFF), 1'b1,
                         make_beat(1'b0, 8'h00, 7'd0, 7'd0, 32'hFFFF_FFFF, 1'b1)});
        rows.push_back('{make_event(1'b0, 8'hFF, 7'd127, 7'd127, 32'd0), 1'b1,
                         make_beat(1'b0, 8'h00, 7'd0, 7'd0, 32'd0, 1'b1)});
        rows.push_back('{make_event(1'b1, 8'hBF, 7'd127, 7'd127, 32'd5), 1'b1,
                         make_beat(1'b1, 8'hBF, 7'd127, 7'd127, 32'd5, 1'b1)});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd3}, 7'd60, 7'd100, 32'd10),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd3}, 7'd60, 7'd90, 32'd11),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd5}, 7'd64, 7'd50, 32'd12),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_OFF, 4'd5}, 7'd64, 7'd0, 32'd13),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_OFF, 4'd3}, 7'd60, 7'd0, 32'd14),
                         1'b0, none});
        // Velocity zero on a note-on releases the last copy of the root.
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd3}, 7'd60, 7'd0, 32'd15),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_OFF, 4'd0}, 7'd10, 7'd64, 32'd16),
                         1'b1, make_beat(1'b1, 8'h80, 7'd10, 7'd64, 32'd16, 1'b1)});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd0}, 7'd120, 7'd127, 32'd17),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_OFF, 4'd0}, 7'd120, 7'd0, 32'd18),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'hF}, 7'd0, 7'd1, 32'd19),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_OFF, 4'hF}, 7'd0, 7'd127, 32'd20),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd0}, 7'd127, 7'd127, 32'd21),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd0}, 7'd127, 7'd0, 32'd22),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_ON, 4'd9}, 7'd115, 7'd77, 32'd23),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, {TYPE_NOTE_OFF, 4'd9}, 7'd115, 7'd0, 32'd24),
                         1'b0, none});
        rows.push_back('{make_event(1'b1, 8'hE0, 7'd0, 7'd0, 32'd25), 1'b1,
                         make_beat(1'b1, 8'hE0, 7'd0, 7'd0, 32'd25, 1'b1)});
        foreach (rows[i]) send_event(rows[i].item, rows[i].typed, rows[i].want);

        for (int ph = 1; ph <= PHASES; ph++) begin
            ivs[0] = 7'($urandom_range(0, 4));
            for (int i = 1; i < INTERVAL_REGS; i++)
                ivs[i] = ivs[i-1] + 7'($urandom_range(0, 5));
            case (ph)
                1: load_chord(3'd4, ivs);
                2: begin
                    ivs = '{7'd0, 7'd3, 7'd7, 7'd10, 7'd14, 7'd127};
                    load_chord(3'd7, ivs);
                end
                3: load_chord(3'd0, ivs);
                4: begin
                    ivs = '{7'd127, 7'd0, 7'd12, 7'd5, 7'd0, 7'd19};
                    load_chord(3'd6, ivs);
                end
                default: load_chord(3'($urandom_range(1, 6)), ivs);
            endcase
            tx_idle_on = (ph != 1);
            rx_idle_on = (ph != 1);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (ph == 3 && k == 10) hold_request = 400;
                if (ph == 4 && k == 25) wait_drained();
                send_event(random_event(), 1'b0, none);
            end
        end

        // Release whatever is still held so the next part starts from silence.
        for (int p = 0; p < PITCH_COUNT; p++)
            while (key_count[p] != 0)
                send_event(make_event(1'b1, {TYPE_NOTE_OFF, 4'd0}, 7'(p), 7'd0, 32'd0),
                           1'b0, none);

        // Held count saturation: a wrapped count would drop the chord on the last press.
        ivs = '{7'd4, 7'd7, 7'd12, 7'd0, 7'd0, 7'd0};
        load_chord(3'd3, ivs);
        for (int k = 0; k < 257; k++)
            send_event(make_event(1'b1, {TYPE_NOTE_ON, 4'd2}, 7'd30, 7'd64, k), 1'b0, none);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_beats.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d beats never arrived", pending_beats.size());
        end
        $display("Ran %0d events through %0d chord settings; %0d beats checked, %0d generated.",
                 items_sent, PHASES + 2, beats_seen, chord_notes_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS midi_single_note_chord_generator");
        else
            $display("FAIL midi_single_note_chord_generator");
        $finish;
    end

endmodule
